[rtl/bpa_pkg.sv]
// shared constants, codes and types of the buddy page allocator
`default_nettype none

package bpa_pkg;

	localparam int unsigned POOL_PAGE_LIMIT = 32768;
	localparam int unsigned PAGE_W     = $clog2(POOL_PAGE_LIMIT);
	localparam int unsigned POOL_W     = 16;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned RANK_LIMIT = 16;
	localparam int unsigned RANK_W     = 5;
	localparam int unsigned TAG_W      = 6;
	localparam int unsigned PAGE_BYTES = 4 * 1024;
	localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int unsigned OFS_W      = 27;
	localparam int unsigned ACT_W      = 3;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned VAL_W      = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_INIT   = 3'd0,
		ACT_ALLOC  = 3'd1,
		ACT_FREE   = 3'd2,
		ACT_QRANK  = 3'd3,
		ACT_QCOUNT = 3'd4
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_NO_SPACE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_AL_RD,
		S_AL_SPLIT_A,
		S_AL_SPLIT_B,
		S_AL_TAKE,
		S_FR_RD,
		S_FR_CHK,
		S_FR_BUD,
		S_FR_BUDCHK,
		S_WK_RD,
		S_WK_CHK,
		S_FR_MERGE,
		S_FR_PUSH,
		S_QR_RD,
		S_QR_CHK,
		S_QS_RD,
		S_QS_CHK,
		S_REPLY
	} state_t;

endpackage

`default_nettype wire

[rtl/bpa_req_if.sv]
// request channel: action, rank and byte offset with valid/ready
`default_nettype none

interface bpa_req_if
	import bpa_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [RANK_W-1:0] rank;
	logic [OFS_W-1:0]  byte_offset;

	modport source (output valid, action, rank, byte_offset, input ready);
	modport sink (input valid, action, rank, byte_offset, output ready);
endinterface

`default_nettype wire

[rtl/bpa_rsp_if.sv]
// response channel: status, allocated offset and query value with valid/ready
`default_nettype none

interface bpa_rsp_if
	import bpa_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [OFS_W-1:0]  alloc_offset;
	logic [VAL_W-1:0]  value;

	modport source (output valid, status, alloc_offset, value, input ready);
	modport sink (input valid, status, alloc_offset, value, output ready);
endinterface

`default_nettype wire

[rtl/buddy_page_allocator_top.sv]
// buddy page allocator: tag and link memories with a read-modify-write sequencer
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  req     | in  | valid/ready         | action, rank, byte_offset
//  rsp     | out | valid/ready         | status, alloc_offset, value
//  cfg     | in  | cfg_we, no ready    | cfg_wdata = pool_pages
//
//  one item in flight; an item enters only in the idle state, and the result
//  register lets the next item in while the previous result waits on rsp
//  count queries and items rejected on decode go straight to the reply state;
//  alloc splits one rank at a time down to the requested rank; free replies
//  without a merge when the block is not allocated, and per merge checks the
//  buddy's tag and walks the free list in the link memory looking for it; rank
//  query probes the ranks from the top down when the page is no block start;
//  init sweeps page by page over the pool in the tag and link memories
//  reset clears control state only; the memories are rebuilt by init
`default_nettype none

module buddy_page_allocator_top
	import bpa_pkg::*;
	(
	input  wire               clk,
	input  wire               arst_n,
	bpa_req_if.sink           req,
	bpa_rsp_if.source         rsp,
	input  wire               cfg_we,
	input  wire [POOL_W-1:0]  cfg_wdata
);

	// page tag memory: bit 5 allocated, bits 4..0 rank of a block start
	logic [TAG_W-1:0]  tag_mem [POOL_PAGE_LIMIT];
	// next-link memory of the free lists
	logic [PAGE_W-1:0] link_mem [POOL_PAGE_LIMIT];

	logic              tag_we, link_we;
	logic [PAGE_W-1:0] tag_wa, tag_ra, link_wa, link_ra;
	logic [TAG_W-1:0]  tag_wd;
	logic [PAGE_W-1:0] link_wd;
	logic [TAG_W-1:0]  tag_rd_q;
	logic [PAGE_W-1:0] link_rd_q;

	// sequencer state
	state_t            state_q, state_d;
	logic [POOL_W-1:0] pool_q;
	logic [POOL_W-1:0] live_q;
	logic [RANK_W-1:0] top_q;
	logic              ready_q;
	logic [PAGE_W-1:0] head_q [RANK_LIMIT+1];
	logic [CNT_W-1:0]  cnt_q  [RANK_LIMIT+1];

	// working registers of the current item
	logic [RANK_W-1:0] rank_q, cur_q;
	logic [PAGE_W-1:0] blk_q, bud_q, link_q, walk_q, prev_q;
	logic [CNT_W-1:0]  idx_q, n_q;
	logic [PAGE_W-1:0] sweep_q, init_mask_q;
	logic [POOL_W-1:0] init_end_q;

	// result held until the output register is free
	status_t           res_status_q;
	logic [OFS_W-1:0]  res_ofs_q;
	logic [VAL_W-1:0]  res_val_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [OFS_W-1:0]  out_ofs_q;
	logic [VAL_W-1:0]  out_val_q;

	// decode of the incoming item
	logic              accept, out_free;
	logic              rank_ok, pool_ok, pg_ok;
	logic [PAGE_W-1:0] pg_in;
	logic              al_found;
	logic [RANK_W-1:0] al_rank;

	// init geometry from the pool size
	logic [RANK_W-1:0] init_rank;
	logic [POOL_W-1:0] init_mask16, init_end, init_blocks;
	logic [PAGE_W-1:0] init_head;
	logic [PAGE_W-1:0] sweep_tag_hit;
	logic              sweep_last;

	// helpers of the split, merge and rank search steps
	logic [RANK_W-1:0] cur_m1, cur_m2, cur_p1, tag_rank;
	logic [PAGE_W-1:0] split_bud, fr_bud, qs_first, blk_min, blk_max;
	logic              tag_ok, merge_go, any_cnt;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.alloc_offset = out_ofs_q;
	assign rsp.value        = out_val_q;

	assign rank_ok = (req.rank >= RANK_W'(1)) && (req.rank <= RANK_W'(RANK_LIMIT));
	assign pool_ok = (pool_q != '0) && (pool_q <= POOL_W'(POOL_PAGE_LIMIT));
	assign pg_in   = req.byte_offset[PAGE_SHIFT +: PAGE_W];
	// page lookup: pool set up, page aligned, page inside the live pool
	assign pg_ok   = ready_q && (req.byte_offset[PAGE_SHIFT-1:0] == '0)
		&& ({1'b0, pg_in} < live_q);

	assign cur_m1   = cur_q - RANK_W'(1);
	assign cur_m2   = cur_q - RANK_W'(2);
	assign cur_p1   = cur_q + RANK_W'(1);
	assign tag_rank = tag_rd_q[RANK_W-1:0];
	assign tag_ok   = tag_rd_q[TAG_W-1] && (tag_rank >= RANK_W'(1))
		&& (tag_rank <= RANK_W'(RANK_LIMIT));

	// buddy of the block being split (one rank below cur) and being merged
	assign split_bud = blk_q ^ (PAGE_W'(1) << cur_m2);
	assign fr_bud    = blk_q ^ (PAGE_W'(1) << cur_m1);
	assign merge_go  = (cur_q < top_q) && ({1'b0, fr_bud} < live_q);
	assign qs_first  = blk_q & ~((PAGE_W'(1) << cur_m1) - PAGE_W'(1));
	assign blk_min   = (blk_q < bud_q) ? blk_q : bud_q;
	assign blk_max   = (blk_q < bud_q) ? bud_q : blk_q;

	// smallest non-empty rank at or above the request, up to the top rank
	always_comb begin
		al_found = 1'b0;
		al_rank  = '0;
		for (int c = RANK_LIMIT; c >= 1; c--) begin
			if (cnt_q[c] != '0 && RANK_W'(c) >= req.rank && RANK_W'(c) <= top_q) begin
				al_found = 1'b1;
				al_rank  = RANK_W'(c);
			end
		end
	end

	always_comb begin
		any_cnt = 1'b0;
		for (int i = 0; i <= RANK_LIMIT; i++) begin
			any_cnt = any_cnt | (cnt_q[i] != '0);
		end
	end

	// top rank: leading one of the pool size plus one, capped
	always_comb begin
		int msb;
		msb = 0;
		for (int i = 0; i < POOL_W; i++) begin
			if (pool_q[i]) begin
				msb = i;
			end
		end
		if (msb + 1 > RANK_LIMIT) begin
			init_rank = RANK_W'(RANK_LIMIT);
		end else begin
			init_rank = RANK_W'(msb + 1);
		end
	end

	assign init_mask16 = (POOL_W'(1) << (init_rank - RANK_W'(1))) - POOL_W'(1);
	assign init_end    = pool_q & ~init_mask16;
	assign init_blocks = pool_q >> (init_rank - RANK_W'(1));
	assign init_head   = PAGE_W'(init_end - (POOL_W'(1) << (init_rank - RANK_W'(1))));

	// sweep page is a block start when aligned and below the end of the last whole block
	assign sweep_tag_hit = sweep_q & init_mask_q;
	assign sweep_last    = ({1'b0, sweep_q} == live_q - POOL_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (act_t'(req.action))
						ACT_INIT:  state_d = pool_ok ? S_INIT : S_REPLY;
						ACT_ALLOC: state_d = (rank_ok && al_found) ? S_AL_RD : S_REPLY;
						ACT_FREE:  state_d = pg_ok ? S_FR_RD : S_REPLY;
						ACT_QRANK: state_d = pg_ok ? S_QR_RD : S_REPLY;
						default:   state_d = S_REPLY;
					endcase
				end
			end
			S_INIT:       state_d = sweep_last ? S_REPLY : S_INIT;
			S_AL_RD:      state_d = (cur_q == rank_q) ? S_AL_TAKE : S_AL_SPLIT_A;
			S_AL_SPLIT_A: state_d = S_AL_SPLIT_B;
			S_AL_SPLIT_B: state_d = S_AL_RD;
			S_AL_TAKE:    state_d = S_REPLY;
			S_FR_RD:      state_d = S_FR_CHK;
			S_FR_CHK:     state_d = tag_ok ? S_FR_BUD : S_REPLY;
			S_FR_BUD:     state_d = merge_go ? S_FR_BUDCHK : S_REPLY;
			S_FR_BUDCHK:  state_d = (tag_rd_q == {1'b0, cur_q}) ? S_WK_RD : S_REPLY;
			S_WK_RD:      state_d = (idx_q == n_q) ? S_REPLY : S_WK_CHK;
			S_WK_CHK:     state_d = (walk_q == bud_q) ? S_FR_MERGE : S_WK_RD;
			S_FR_MERGE:   state_d = S_FR_PUSH;
			S_FR_PUSH:    state_d = S_FR_BUD;
			S_QR_RD:      state_d = S_QR_CHK;
			S_QR_CHK:     state_d = (tag_rd_q != '0) ? S_REPLY : S_QS_RD;
			S_QS_RD:      state_d = (cur_q == '0) ? S_REPLY : S_QS_CHK;
			S_QS_CHK: begin
				if (tag_rd_q != '0 && tag_rank == cur_q) begin
					state_d = S_REPLY;
				end else begin
					state_d = S_QS_RD;
				end
			end
			S_REPLY:      state_d = out_free ? S_IDLE : S_REPLY;
			default:      state_d = S_IDLE;
		endcase
	end

	// memory port controls and input ready
	always_comb begin
		req.ready = (state_q == S_IDLE);
		tag_we    = 1'b0;
		tag_wa    = blk_q;
		tag_wd    = '0;
		tag_ra    = blk_q;
		link_we   = 1'b0;
		link_wa   = blk_q;
		link_wd   = '0;
		link_ra   = blk_q;
		case (state_q)
			S_INIT: begin
				tag_we  = 1'b1;
				tag_wa  = sweep_q;
				tag_wd  = (sweep_tag_hit == '0 && {1'b0, sweep_q} < init_end_q)
					? {1'b0, top_q} : '0;
				link_we = 1'b1;
				link_wa = sweep_q;
				link_wd = sweep_q - (init_mask_q + PAGE_W'(1));
			end
			S_AL_RD: begin
				link_ra = head_q[cur_q];
			end
			S_AL_SPLIT_A: begin
				// upper half goes onto the list first
				tag_we  = 1'b1;
				tag_wa  = split_bud;
				tag_wd  = {1'b0, cur_m1};
				link_we = 1'b1;
				link_wa = split_bud;
				link_wd = head_q[cur_m1];
			end
			S_AL_SPLIT_B: begin
				tag_we  = 1'b1;
				tag_wd  = {1'b0, cur_m1};
				link_we = 1'b1;
				link_wd = bud_q;
			end
			S_AL_TAKE: begin
				tag_we = 1'b1;
				tag_wd = {1'b1, rank_q};
			end
			S_FR_CHK: begin
				if (tag_ok) begin
					tag_we  = 1'b1;
					tag_wd  = {1'b0, tag_rank};
					link_we = 1'b1;
					link_wd = head_q[tag_rank];
				end
			end
			S_FR_BUD: begin
				tag_ra = fr_bud;
			end
			S_WK_RD: begin
				link_ra = walk_q;
			end
			S_WK_CHK: begin
				// buddy found deeper in the list: bypass it
				if (walk_q == bud_q && idx_q != '0) begin
					link_we = 1'b1;
					link_wa = prev_q;
					link_wd = link_rd_q;
				end
			end
			S_FR_MERGE: begin
				tag_we = 1'b1;
				tag_wa = blk_max;
				tag_wd = '0;
			end
			S_FR_PUSH: begin
				tag_we  = 1'b1;
				tag_wd  = {1'b0, cur_p1};
				link_we = 1'b1;
				link_wd = head_q[cur_p1];
			end
			S_QS_RD: begin
				tag_ra = qs_first;
			end
			default: begin
			end
		endcase
	end

	// memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		tag_rd_q <= tag_mem[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd_q <= link_mem[link_ra];
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_q       <= POOL_W'(POOL_PAGE_LIMIT);
			live_q       <= '0;
			top_q        <= '0;
			ready_q      <= 1'b0;
			for (int i = 0; i <= RANK_LIMIT; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			rank_q       <= '0;
			cur_q        <= '0;
			blk_q        <= '0;
			bud_q        <= '0;
			link_q       <= '0;
			walk_q       <= '0;
			prev_q       <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			sweep_q      <= '0;
			init_mask_q  <= '0;
			init_end_q   <= '0;
			res_status_q <= ST_OK;
			res_ofs_q    <= '0;
			res_val_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_ofs_q    <= '0;
			out_val_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			// the reply state reloads the output register itself
			if (out_valid_q && rsp.ready && state_q != S_REPLY) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rank_q    <= req.rank;
						blk_q     <= pg_in;
						res_ofs_q <= '0;
						case (act_t'(req.action))
							ACT_INIT: begin
								cur_q     <= top_q;
								res_val_q <= '0;
								if (pool_ok) begin
									live_q  <= pool_q;
									top_q   <= init_rank;
									ready_q <= 1'b1;
									for (int i = 0; i <= RANK_LIMIT; i++) begin
										head_q[i] <= (RANK_W'(i) == init_rank) ? init_head : '0;
										cnt_q[i]  <= (RANK_W'(i) == init_rank) ? init_blocks : '0;
									end
									init_mask_q  <= PAGE_W'(init_mask16);
									init_end_q   <= init_end;
									sweep_q      <= '0;
									res_status_q <= ST_OK;
								end else begin
									res_status_q <= ST_INVALID;
								end
							end
							ACT_ALLOC: begin
								res_status_q <= (rank_ok && !al_found) ? ST_NO_SPACE
									: ST_INVALID;
								res_val_q    <= '0;
								cur_q        <= al_rank;
							end
							ACT_QCOUNT: begin
								cur_q <= top_q;
								if (rank_ok) begin
									res_status_q <= ST_OK;
									res_val_q    <= cnt_q[req.rank];
								end else begin
									res_status_q <= ST_INVALID;
									res_val_q    <= '0;
								end
							end
							default: begin
								cur_q        <= top_q;
								res_status_q <= ST_INVALID;
								res_val_q    <= '0;
							end
						endcase
					end
				end
				S_INIT: begin
					sweep_q <= sweep_q + PAGE_W'(1);
				end
				S_AL_RD: begin
					blk_q <= head_q[cur_q];
				end
				S_AL_SPLIT_A: begin
					head_q[cur_q] <= link_rd_q;
					cnt_q[cur_q]  <= cnt_q[cur_q] - CNT_W'(1);
					bud_q         <= split_bud;
				end
				S_AL_SPLIT_B: begin
					head_q[cur_m1] <= blk_q;
					cnt_q[cur_m1]  <= cnt_q[cur_m1] + CNT_W'(2);
					cur_q          <= cur_m1;
				end
				S_AL_TAKE: begin
					head_q[rank_q] <= link_rd_q;
					cnt_q[rank_q]  <= cnt_q[rank_q] - CNT_W'(1);
					res_status_q   <= ST_OK;
					res_ofs_q      <= OFS_W'({blk_q, {PAGE_SHIFT{1'b0}}});
				end
				S_FR_CHK: begin
					if (tag_ok) begin
						cur_q            <= tag_rank;
						link_q           <= head_q[tag_rank];
						head_q[tag_rank] <= blk_q;
						cnt_q[tag_rank]  <= cnt_q[tag_rank] + CNT_W'(1);
						res_status_q     <= ST_OK;
					end
				end
				S_FR_BUD: begin
					bud_q <= fr_bud;
				end
				S_FR_BUDCHK: begin
					// freed block sits at the head: drop it, then search the buddy
					if (tag_rd_q == {1'b0, cur_q}) begin
						head_q[cur_q] <= link_q;
						cnt_q[cur_q]  <= cnt_q[cur_q] - CNT_W'(1);
						walk_q        <= link_q;
						idx_q         <= '0;
						n_q           <= cnt_q[cur_q] - CNT_W'(1);
					end
				end
				S_WK_CHK: begin
					if (walk_q == bud_q) begin
						if (idx_q == '0) begin
							head_q[cur_q] <= link_rd_q;
						end
						cnt_q[cur_q] <= cnt_q[cur_q] - CNT_W'(1);
					end else begin
						prev_q <= walk_q;
						walk_q <= link_rd_q;
						idx_q  <= idx_q + CNT_W'(1);
					end
				end
				S_FR_MERGE: begin
					blk_q <= blk_min;
				end
				S_FR_PUSH: begin
					link_q         <= head_q[cur_p1];
					head_q[cur_p1] <= blk_q;
					cnt_q[cur_p1]  <= cnt_q[cur_p1] + CNT_W'(1);
					cur_q          <= cur_p1;
				end
				S_QR_CHK: begin
					if (tag_rd_q != '0) begin
						res_status_q <= ST_OK;
						res_val_q    <= VAL_W'(tag_rank);
					end
				end
				S_QS_CHK: begin
					if (tag_rd_q != '0 && tag_rank == cur_q) begin
						res_status_q <= ST_OK;
						res_val_q    <= VAL_W'(cur_q);
					end else begin
						cur_q <= cur_m1;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_ofs_q    <= res_ofs_q;
						out_val_q    <= res_val_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// a waiting result is never dropped by the sequencer
	a_reply_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPLY && out_valid_q && !rsp.ready) |=> (state_q == S_REPLY))
		else $error("result left before the output register was free");

	// no free block exists before the pool has been set up
	a_empty_before_init: assert property (@(posedge clk) disable iff (!arst_n)
		!ready_q |-> !any_cnt)
		else $error("free count nonzero before init");

	// list walk never runs past the list length
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WK_RD || state_q == S_WK_CHK) |-> (idx_q <= n_q))
		else $error("list walk overran the list");

	// allocation only splits from a rank within the pool
	a_split_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AL_SPLIT_A) |-> (cur_q > rank_q && cur_q <= top_q))
		else $error("split from a rank outside the requested range");

endmodule

`default_nettype wire
